@@ design/lsrb_pkg.sv @@
// ----------------------------------------------------------------------------
// lsrb_pkg
// Shared types and constants of the link supervisor with retry back-off.
// ----------------------------------------------------------------------------
package lsrb_pkg;

    // command codes
    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_RECONNECT   = 3'd1;
    localparam logic [2:0] CMD_UPD_BEGIN   = 3'd2;
    localparam logic [2:0] CMD_UPD_DONE    = 3'd3;
    localparam logic [2:0] CMD_UPD_FAILED  = 3'd4;

    // link modes, also used as status codes
    localparam logic [2:0] MODE_CONNECTING   = 3'd0;
    localparam logic [2:0] MODE_ACTIVE       = 3'd1;
    localparam logic [2:0] MODE_RECONNECTING = 3'd2;
    localparam logic [2:0] MODE_ERROR        = 3'd3;
    localparam logic [2:0] MODE_UPDATING     = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_UPDATE_PERIOD = 3'd0;
    localparam logic [2:0] REG_HEARTBEAT     = 3'd1;
    localparam logic [2:0] REG_CONN_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_RETRY         = 3'd3;
    localparam logic [2:0] REG_BACKOFF       = 3'd4;
    localparam logic [2:0] REG_UPD_MAX       = 3'd5;
    localparam logic [2:0] REG_MAX_ATTEMPTS  = 3'd6;

    // configuration reset values
    localparam logic [15:0] DEF_UPDATE_PERIOD = 16'd1000;
    localparam logic [31:0] DEF_HEARTBEAT     = 32'd300000;
    localparam logic [31:0] DEF_CONN_TIMEOUT  = 32'd90000;
    localparam logic [31:0] DEF_RETRY         = 32'd30000;
    localparam logic [31:0] DEF_BACKOFF       = 32'd60000;
    localparam logic [31:0] DEF_UPD_MAX       = 32'd300000;
    localparam logic [7:0]  DEF_MAX_ATTEMPTS  = 8'd3;

    localparam logic [7:0]  ATTEMPTS_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] update_period;
        logic [31:0] heartbeat;
        logic [31:0] conn_timeout;
        logic [31:0] retry;
        logic [31:0] backoff;
        logic [31:0] upd_max;
        logic [7:0]  max_attempts;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] now_ms;
        logic        link_ready;
        logic        cloud_up;
    } t_item;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  status;
        logic [31:0] entered_at;
        logic [7:0]  attempts;
        logic [31:0] last_tick;
        logic [31:0] last_hb;
        logic [31:0] last_retry;
        logic [31:0] upd_start;
        logic        upd_busy;
        logic        warned;
    } t_state;

    typedef struct packed {
        logic [2:0] link_state;
        logic [2:0] status_code;
        logic [7:0] attempt_count;
        logic       request_rejected;
        logic       start_tether;
        logic       connect_request;
        logic       disconnect_request;
        logic       announce_connected;
        logic       heartbeat_due;
        logic       connect_warning;
    } t_result;

endpackage

@@ design/lsrb_in_if.sv @@
// ----------------------------------------------------------------------------
// lsrb_in_if
// Command channel: valid/ready handshake with one command transaction.
// ----------------------------------------------------------------------------
interface lsrb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic        link_ready;
    logic        cloud_up;

    modport source (output valid, command, now_ms, link_ready, cloud_up, input ready);
    modport sink   (input valid, command, now_ms, link_ready, cloud_up, output ready);
endinterface

@@ design/lsrb_out_if.sv @@
// ----------------------------------------------------------------------------
// lsrb_out_if
// Result channel: valid/ready handshake with one result transaction.
// ----------------------------------------------------------------------------
interface lsrb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] link_state;
    logic [2:0] status_code;
    logic [7:0] attempt_count;
    logic       request_rejected;
    logic       start_tether;
    logic       connect_request;
    logic       disconnect_request;
    logic       announce_connected;
    logic       heartbeat_due;
    logic       connect_warning;

    modport source (
        output valid, link_state, status_code, attempt_count, request_rejected,
               start_tether, connect_request, disconnect_request,
               announce_connected, heartbeat_due, connect_warning,
        input  ready
    );
    modport sink (
        input  valid, link_state, status_code, attempt_count, request_rejected,
               start_tether, connect_request, disconnect_request,
               announce_connected, heartbeat_due, connect_warning,
        output ready
    );
endinterface

@@ design/lsrb_step.sv @@
// ----------------------------------------------------------------------------
// lsrb_step
// Next-state and result logic for one command transaction.
// ----------------------------------------------------------------------------
module lsrb_step (
    input  lsrb_pkg::t_cfg    i_cfg,
    input  lsrb_pkg::t_state  i_state,
    input  lsrb_pkg::t_item   i_item,
    output lsrb_pkg::t_state  o_state,
    output lsrb_pkg::t_result o_result
);

    // switch mode and stamp entry time only on a real change
    function automatic lsrb_pkg::t_state f_enter(lsrb_pkg::t_state s, logic [2:0] m,
                                                 logic [31:0] now);
        lsrb_pkg::t_state r;
        r = s;
        if (s.mode != m) begin
            r.mode       = m;
            r.entered_at = now;
        end
        return r;
    endfunction

    logic [31:0] now;
    logic [31:0] dt_tick, dt_entered, dt_hb, dt_retry, dt_upd;
    logic [31:0] upd_start_eff;
    logic [7:0]  att_inc;
    logic        both_up;

    assign now           = i_item.now_ms;
    assign both_up       = i_item.link_ready && i_item.cloud_up;
    assign upd_start_eff = (i_state.upd_start == 32'd0) ? now : i_state.upd_start;
    assign dt_tick       = now - i_state.last_tick;
    assign dt_entered    = now - i_state.entered_at;
    assign dt_hb         = now - i_state.last_hb;
    assign dt_retry      = now - i_state.last_retry;
    assign dt_upd        = now - upd_start_eff;
    assign att_inc       = (i_state.attempts < lsrb_pkg::ATTEMPTS_MAX) ?
                           i_state.attempts + 8'd1 : i_state.attempts;

    // evaluate the command against the current state
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.command)
            lsrb_pkg::CMD_TICK: begin
                if (dt_tick >= {16'd0, i_cfg.update_period}) begin
                    o_state.last_tick = now;
                    case (i_state.mode)
                        lsrb_pkg::MODE_CONNECTING: begin
                            if (both_up) begin
                                o_result.start_tether       = 1'b1;
                                o_result.announce_connected = 1'b1;
                                o_state.status   = lsrb_pkg::MODE_ACTIVE;
                                o_state.attempts = 8'd0;
                                o_state = f_enter(o_state, lsrb_pkg::MODE_ACTIVE, now);
                            end else if (dt_entered > i_cfg.conn_timeout &&
                                         !i_state.warned) begin
                                o_result.connect_warning = 1'b1;
                                o_state.warned           = 1'b1;
                            end
                        end
                        lsrb_pkg::MODE_ACTIVE: begin
                            o_state.status = lsrb_pkg::MODE_ACTIVE;
                            if (dt_hb > i_cfg.heartbeat) begin
                                o_result.heartbeat_due = 1'b1;
                                o_state.last_hb        = now;
                            end
                            if (!i_item.link_ready) begin
                                o_state.status = lsrb_pkg::MODE_RECONNECTING;
                                o_state = f_enter(o_state, lsrb_pkg::MODE_RECONNECTING, now);
                            end
                        end
                        lsrb_pkg::MODE_RECONNECTING: begin
                            o_state.status = lsrb_pkg::MODE_RECONNECTING;
                            if (both_up) begin
                                o_state.attempts      = 8'd0;
                                o_result.start_tether = 1'b1;
                                o_state = f_enter(o_state, lsrb_pkg::MODE_ACTIVE, now);
                            end else if (dt_retry > i_cfg.retry) begin
                                o_state.last_retry = now;
                                o_state.attempts   = att_inc;
                                if (att_inc >= i_cfg.max_attempts) begin
                                    o_state.status = lsrb_pkg::MODE_ERROR;
                                    o_state = f_enter(o_state, lsrb_pkg::MODE_ERROR, now);
                                end else begin
                                    o_result.connect_request = 1'b1;
                                end
                            end
                        end
                        lsrb_pkg::MODE_ERROR: begin
                            o_state.status = lsrb_pkg::MODE_ERROR;
                            if (dt_entered > i_cfg.backoff) begin
                                o_state.attempts         = 8'd0;
                                o_result.connect_request = 1'b1;
                                o_state = f_enter(o_state, lsrb_pkg::MODE_RECONNECTING, now);
                            end
                        end
                        lsrb_pkg::MODE_UPDATING: begin
                            o_state.status = lsrb_pkg::MODE_UPDATING;
                            if (!i_state.upd_busy) begin
                                o_state.upd_start = 32'd0;
                            end else if (dt_upd >= i_cfg.upd_max) begin
                                o_state.upd_busy  = 1'b0;
                                o_state.upd_start = 32'd0;
                                o_state = f_enter(o_state, lsrb_pkg::MODE_ACTIVE, now);
                            end else begin
                                o_state.upd_start = upd_start_eff;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lsrb_pkg::CMD_RECONNECT: begin
                if (i_state.mode == lsrb_pkg::MODE_RECONNECTING) begin
                    o_result.request_rejected = 1'b1;
                end else begin
                    o_result.disconnect_request = 1'b1;
                    o_state.attempts            = 8'd0;
                    o_state = f_enter(o_state, lsrb_pkg::MODE_RECONNECTING, now);
                end
            end
            lsrb_pkg::CMD_UPD_BEGIN: begin
                o_state.upd_busy = 1'b1;
                o_state = f_enter(o_state, lsrb_pkg::MODE_UPDATING, now);
            end
            lsrb_pkg::CMD_UPD_DONE: begin
                o_state.upd_busy = 1'b0;
            end
            lsrb_pkg::CMD_UPD_FAILED: begin
                o_state.upd_busy = 1'b0;
                o_state = f_enter(o_state, lsrb_pkg::MODE_ACTIVE, now);
            end
            default: begin
            end
        endcase
        o_result.link_state    = o_state.mode;
        o_result.status_code   = o_state.status;
        o_result.attempt_count = o_state.attempts;
    end

endmodule

@@ design/link_supervisor_retry_backoff_top.sv @@
// ----------------------------------------------------------------------------
// link_supervisor_retry_backoff_top
// Link supervisor with retry back-off: one result per command transaction.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | contents
//  i_cmd    | in  | valid/ready          | command, now_ms, link_ready, cloud_up
//  o_res    | out | valid/ready          | mode, status, attempts, action pulses
//  i_cfg_*  | in  | write enable, no ack | register index, 32-bit data
//
//  A command transaction lands in the input register, is evaluated against
//  the supervisor state and written to the result register.
//  One transaction is taken every cycle while the result side keeps taking.
//  A stalled result holds in the result register while one more command waits
//  in the input register; the supervisor state advances only as a command moves on.
//  Synchronous active-low reset loads the default configuration and clears state.
// ----------------------------------------------------------------------------
module link_supervisor_retry_backoff_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsrb_in_if.sink       i_cmd,
    lsrb_out_if.source    o_res,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    lsrb_pkg::t_cfg    r_cfg;
    lsrb_pkg::t_state  r_state, n_state;
    lsrb_pkg::t_item   r_item;
    lsrb_pkg::t_result r_out, n_out;
    logic              r_item_valid;
    logic              r_out_valid;
    logic              advance;

    // move the held command forward when the result register is free
    assign advance     = r_item_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_item_valid || advance;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_period <= lsrb_pkg::DEF_UPDATE_PERIOD;
            r_cfg.heartbeat     <= lsrb_pkg::DEF_HEARTBEAT;
            r_cfg.conn_timeout  <= lsrb_pkg::DEF_CONN_TIMEOUT;
            r_cfg.retry         <= lsrb_pkg::DEF_RETRY;
            r_cfg.backoff       <= lsrb_pkg::DEF_BACKOFF;
            r_cfg.upd_max       <= lsrb_pkg::DEF_UPD_MAX;
            r_cfg.max_attempts  <= lsrb_pkg::DEF_MAX_ATTEMPTS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lsrb_pkg::REG_UPDATE_PERIOD: r_cfg.update_period <= i_cfg_data[15:0];
                lsrb_pkg::REG_HEARTBEAT:     r_cfg.heartbeat     <= i_cfg_data;
                lsrb_pkg::REG_CONN_TIMEOUT:  r_cfg.conn_timeout  <= i_cfg_data;
                lsrb_pkg::REG_RETRY:         r_cfg.retry         <= i_cfg_data;
                lsrb_pkg::REG_BACKOFF:       r_cfg.backoff       <= i_cfg_data;
                lsrb_pkg::REG_UPD_MAX:       r_cfg.upd_max       <= i_cfg_data;
                lsrb_pkg::REG_MAX_ATTEMPTS:  r_cfg.max_attempts  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // capture an incoming command transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_item_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_item.command    <= i_cmd.command;
            r_item.now_ms     <= i_cmd.now_ms;
            r_item.link_ready <= i_cmd.link_ready;
            r_item.cloud_up   <= i_cmd.cloud_up;
        end
    end

    // evaluate the held command
    lsrb_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // advance supervisor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= lsrb_pkg::MODE_CONNECTING;
            r_state.status     <= lsrb_pkg::MODE_CONNECTING;
            r_state.entered_at <= 32'd0;
            r_state.attempts   <= 8'd0;
            r_state.last_tick  <= 32'd0;
            r_state.last_hb    <= 32'd0;
            r_state.last_retry <= 32'd0;
            r_state.upd_start  <= 32'd0;
            r_state.upd_busy   <= 1'b0;
            r_state.warned     <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.link_state         = r_out.link_state;
    assign o_res.status_code        = r_out.status_code;
    assign o_res.attempt_count      = r_out.attempt_count;
    assign o_res.request_rejected   = r_out.request_rejected;
    assign o_res.start_tether       = r_out.start_tether;
    assign o_res.connect_request    = r_out.connect_request;
    assign o_res.disconnect_request = r_out.disconnect_request;
    assign o_res.announce_connected = r_out.announce_connected;
    assign o_res.heartbeat_due      = r_out.heartbeat_due;
    assign o_res.connect_warning    = r_out.connect_warning;

endmodule

@@ design/lsrb_chk.sv @@
// ----------------------------------------------------------------------------
// lsrb_chk
// Port-level checks of the link supervisor result channel.
// ----------------------------------------------------------------------------
module lsrb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_link_state,
    input logic [2:0] i_status_code,
    input logic [7:0] i_attempt_count,
    input logic       i_rejected,
    input logic       i_disconnect,
    input logic       i_announce,
    input logic       i_heartbeat
);

    // stalled result holds its value
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_link_state) &&
                                   $stable(i_status_code) && $stable(i_attempt_count)))
        else $error("result changed while stalled");

    // a refused reconnect only happens while reconnecting
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_rejected) |-> (i_link_state == lsrb_pkg::MODE_RECONNECTING &&
                                     !i_disconnect))
        else $error("reconnect rejected outside reconnecting mode");

    // an accepted remote reconnect lands in reconnecting with a cleared counter
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_disconnect) |-> (i_link_state == lsrb_pkg::MODE_RECONNECTING &&
                                       i_attempt_count == 8'd0))
        else $error("disconnect without reconnecting entry");

    // connected announcement reports active with no attempts
    a_announce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_announce) |-> (i_link_state == lsrb_pkg::MODE_ACTIVE &&
                                     i_status_code == lsrb_pkg::MODE_ACTIVE &&
                                     i_attempt_count == 8'd0))
        else $error("announce outside active entry");

    // heartbeat comes only from an active evaluation
    a_hb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_heartbeat) |-> (i_status_code == lsrb_pkg::MODE_ACTIVE ||
                                      i_status_code == lsrb_pkg::MODE_RECONNECTING))
        else $error("heartbeat outside active mode");

endmodule

bind link_supervisor_retry_backoff_top lsrb_chk u_lsrb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_link_state    (o_res.link_state),
    .i_status_code   (o_res.status_code),
    .i_attempt_count (o_res.attempt_count),
    .i_rejected      (o_res.request_rejected),
    .i_disconnect    (o_res.disconnect_request),
    .i_announce      (o_res.announce_connected),
    .i_heartbeat     (o_res.heartbeat_due)
);

@@ dv/link_supervisor_retry_backoff_top_test.sv @@
// ----------------------------------------------------------------------------
// link_supervisor_retry_backoff_top_test
// Self-checking bench for the link supervisor. A driver feeds command
// transactions from a backlog. A local model of the supervisor predicts
// one report per command. A monitor checks every report field by field
// against the oldest prediction. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module link_supervisor_retry_backoff_top_test;

    // reserved command codes and the unused register slot
    localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI  = 3'd7;
    localparam logic [2:0] REG_UNUSED   = 3'd7;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE  = 86;
    localparam int NUM_PHASES       = 8;

    typedef enum int {CFG_SMALL, CFG_MIXED, CFG_DEFAULT, CFG_ZERO, CFG_FULL} t_cfg_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    lsrb_in_if  cmd_if ();
    lsrb_out_if res_if ();

    link_supervisor_retry_backoff_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // model copy of configuration and supervisor state
    lsrb_pkg::t_cfg    cfg;
    lsrb_pkg::t_state  sup;

    lsrb_pkg::t_item   queued_cmds[$];
    lsrb_pkg::t_result predicted_reports[$];
    int                mismatch_count = 0;

    // traffic shaping; settings written by the sequence at the falling edge, gap counters kept by driver and monitor
    bit          tx_no_idle = 1'b0;
    bit          rx_no_idle = 1'b0;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          rx_hold = 0;
    int          rx_gap = 0;
    int          tx_gap = 0;
    logic [31:0] clock_ms;
    logic [31:0] step_scale;
    logic        link_cond;
    logic        cloud_cond;

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // supervisor model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] elapsed(input logic [31:0] later, input logic [31:0] earlier);
        return later - earlier;
    endfunction

    function automatic void switch_mode(input logic [2:0] m, input logic [31:0] now);
        if (sup.mode != m) begin
            sup.mode       = m;
            sup.entered_at = now;
        end
    endfunction

    function automatic lsrb_pkg::t_result supervise_link(input lsrb_pkg::t_item it);
        lsrb_pkg::t_result r;
        logic [31:0]       now;
        r   = '0;
        now = it.now_ms;
        case (it.command)
            lsrb_pkg::CMD_TICK: begin
                // evaluate only once the update period has passed
                if (elapsed(now, sup.last_tick) >= 32'(cfg.update_period)) begin
                    sup.last_tick = now;
                    case (sup.mode)
                        lsrb_pkg::MODE_CONNECTING: begin
                            if (it.link_ready && it.cloud_up) begin
                                r.start_tether       = 1'b1;
                                r.announce_connected = 1'b1;
                                sup.status           = lsrb_pkg::MODE_ACTIVE;
                                sup.attempts         = '0;
                                switch_mode(lsrb_pkg::MODE_ACTIVE, now);
                            end else if (elapsed(now, sup.entered_at) > cfg.conn_timeout
                                         && !sup.warned) begin
                                r.connect_warning = 1'b1;
                                sup.warned        = 1'b1;
                            end
                        end
                        lsrb_pkg::MODE_ACTIVE: begin
                            sup.status = lsrb_pkg::MODE_ACTIVE;
                            if (elapsed(now, sup.last_hb) > cfg.heartbeat) begin
                                r.heartbeat_due = 1'b1;
                                sup.last_hb     = now;
                            end
                            if (!it.link_ready) begin
                                sup.status = lsrb_pkg::MODE_RECONNECTING;
                                switch_mode(lsrb_pkg::MODE_RECONNECTING, now);
                            end
                        end
                        lsrb_pkg::MODE_RECONNECTING: begin
                            sup.status = lsrb_pkg::MODE_RECONNECTING;
                            if (it.link_ready && it.cloud_up) begin
                                sup.attempts   = '0;
                                r.start_tether = 1'b1;
                                switch_mode(lsrb_pkg::MODE_ACTIVE, now);
                            end else if (elapsed(now, sup.last_retry) > cfg.retry) begin
                                sup.last_retry = now;
                                if (sup.attempts < lsrb_pkg::ATTEMPTS_MAX) sup.attempts++;
                                if (sup.attempts >= cfg.max_attempts) begin
                                    sup.status = lsrb_pkg::MODE_ERROR;
                                    switch_mode(lsrb_pkg::MODE_ERROR, now);
                                end else begin
                                    r.connect_request = 1'b1;
                                end
                            end
                        end
                        lsrb_pkg::MODE_ERROR: begin
                            sup.status = lsrb_pkg::MODE_ERROR;
                            if (elapsed(now, sup.entered_at) > cfg.backoff) begin
                                sup.attempts      = '0;
                                r.connect_request = 1'b1;
                                switch_mode(lsrb_pkg::MODE_RECONNECTING, now);
                            end
                        end
                        lsrb_pkg::MODE_UPDATING: begin
                            sup.status = lsrb_pkg::MODE_UPDATING;
                            if (sup.upd_start == '0) sup.upd_start = now;
                            if (!sup.upd_busy) begin
                                sup.upd_start = '0;
                            end else if (elapsed(now, sup.upd_start) >= cfg.upd_max) begin
                                sup.upd_busy  = 1'b0;
                                sup.upd_start = '0;
                                switch_mode(lsrb_pkg::MODE_ACTIVE, now);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lsrb_pkg::CMD_RECONNECT: begin
                if (sup.mode == lsrb_pkg::MODE_RECONNECTING) begin
                    r.request_rejected = 1'b1;
                end else begin
                    r.disconnect_request = 1'b1;
                    sup.attempts         = '0;
                    switch_mode(lsrb_pkg::MODE_RECONNECTING, now);
                end
            end
            lsrb_pkg::CMD_UPD_BEGIN: begin
                sup.upd_busy = 1'b1;
                switch_mode(lsrb_pkg::MODE_UPDATING, now);
            end
            lsrb_pkg::CMD_UPD_DONE: begin
                sup.upd_busy = 1'b0;
            end
            lsrb_pkg::CMD_UPD_FAILED: begin
                sup.upd_busy = 1'b0;
                switch_mode(lsrb_pkg::MODE_ACTIVE, now);
            end
            default: ;
        endcase
        r.link_state    = sup.mode;
        r.status_code   = sup.status;
        r.attempt_count = sup.attempts;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r = $urandom_range(0, 99);
        if (r < 62) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] next_step();
        int r = $urandom_range(0, 99);
        if (r < 8)  return 32'd0;
        if (r < 85) return $urandom_range(0, step_scale);
        if (r < 97) return step_scale * $urandom_range(1, 8);
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // sequence tasks
    // ------------------------------------------------------------------------
    task automatic add_cmd(input logic [2:0] c, input logic [31:0] now,
                           input logic lnk, input logic cld);
        lsrb_pkg::t_item it;
        it.command    = c;
        it.now_ms     = now;
        it.link_ready = lnk;
        it.cloud_up   = cld;
        queued_cmds.push_back(it);
    endtask

    // sticky link flags give runs of good or bad link; a few items are noise
    task automatic add_random_cmd();
        lsrb_pkg::t_item it;
        int              pick;
        logic [1:0]      noise;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 8) link_cond = ~link_cond;
        if ($urandom_range(0, 99) < 8) cloud_cond = ~cloud_cond;
        clock_ms = clock_ms + next_step();
        if (pick < 70)      it.command = lsrb_pkg::CMD_TICK;
        else if (pick < 77) it.command = lsrb_pkg::CMD_RECONNECT;
        else if (pick < 84) it.command = lsrb_pkg::CMD_UPD_BEGIN;
        else if (pick < 90) it.command = lsrb_pkg::CMD_UPD_DONE;
        else if (pick < 96) it.command = lsrb_pkg::CMD_UPD_FAILED;
        else                it.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        it.now_ms = clock_ms;
        if ($urandom_range(0, 99) < 10) begin
            noise         = 2'($urandom);
            it.link_ready = noise[1];
            it.cloud_up   = noise[0];
        end else begin
            it.link_ready = link_cond;
            it.cloud_up   = cloud_cond;
        end
        queued_cmds.push_back(it);
    endtask

    // write one register and mirror it in the model
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            lsrb_pkg::REG_UPDATE_PERIOD: cfg.update_period = data[15:0];
            lsrb_pkg::REG_HEARTBEAT:     cfg.heartbeat     = data;
            lsrb_pkg::REG_CONN_TIMEOUT:  cfg.conn_timeout  = data;
            lsrb_pkg::REG_RETRY:         cfg.retry         = data;
            lsrb_pkg::REG_BACKOFF:       cfg.backoff       = data;
            lsrb_pkg::REG_UPD_MAX:       cfg.upd_max       = data;
            lsrb_pkg::REG_MAX_ATTEMPTS:  cfg.max_attempts  = data[7:0];
            default: ;
        endcase
    endtask

    // program every register; junk in the unused upper bits must be dropped
    task automatic apply_config(input t_cfg_style style);
        lsrb_pkg::t_cfg c;
        case (style)
            CFG_SMALL: begin
                c.update_period = 16'($urandom_range(0, 20));
                c.heartbeat     = $urandom_range(0, 400);
                c.conn_timeout  = $urandom_range(0, 300);
                c.retry         = $urandom_range(0, 100);
                c.backoff       = $urandom_range(0, 200);
                c.upd_max       = $urandom_range(0, 300);
                c.max_attempts  = 8'($urandom_range(0, 6));
                step_scale      = 32'd40;
            end
            CFG_MIXED: begin
                c.update_period = 16'(corner_word());
                c.heartbeat     = corner_word();
                c.conn_timeout  = corner_word();
                c.retry         = corner_word();
                c.backoff       = corner_word();
                c.upd_max       = corner_word();
                c.max_attempts  = 8'(corner_word());
                step_scale      = 32'd1 << $urandom_range(0, 31);
            end
            CFG_DEFAULT: begin
                c = '{lsrb_pkg::DEF_UPDATE_PERIOD, lsrb_pkg::DEF_HEARTBEAT,
                      lsrb_pkg::DEF_CONN_TIMEOUT, lsrb_pkg::DEF_RETRY,
                      lsrb_pkg::DEF_BACKOFF, lsrb_pkg::DEF_UPD_MAX,
                      lsrb_pkg::DEF_MAX_ATTEMPTS};
                step_scale = 32'd20000;
            end
            CFG_ZERO: begin
                c          = '0;
                step_scale = 32'd5;
            end
            default: begin
                c          = '1;
                step_scale = 32'd1 << 17;
            end
        endcase
        write_reg(lsrb_pkg::REG_UPDATE_PERIOD, {16'($urandom), c.update_period});
        write_reg(lsrb_pkg::REG_HEARTBEAT, c.heartbeat);
        write_reg(lsrb_pkg::REG_CONN_TIMEOUT, c.conn_timeout);
        write_reg(lsrb_pkg::REG_RETRY, c.retry);
        write_reg(lsrb_pkg::REG_BACKOFF, c.backoff);
        write_reg(lsrb_pkg::REG_UPD_MAX, c.upd_max);
        write_reg(lsrb_pkg::REG_MAX_ATTEMPTS, {24'($urandom), c.max_attempts});
        @(negedge i_clk);
    endtask

    // hold until the backlog is sent and every report has come back
    task automatic wait_quiet();
        @(negedge i_clk);
        while (queued_cmds.size() != 0 || cmd_if.valid || predicted_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: present queued commands, predict each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        lsrb_pkg::t_item taken;
        lsrb_pkg::t_item upcoming;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                taken.command    = cmd_if.command;
                taken.now_ms     = cmd_if.now_ms;
                taken.link_ready = cmd_if.link_ready;
                taken.cloud_up   = cmd_if.cloud_up;
                predicted_reports.push_back(supervise_link(taken));
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (queued_cmds.size() != 0) begin
                    upcoming = queued_cmds.pop_front();
                    cmd_if.command    <= upcoming.command;
                    cmd_if.now_ms     <= upcoming.now_ms;
                    cmd_if.link_ready <= upcoming.link_ready;
                    cmd_if.cloud_up   <= upcoming.cloud_up;
                    cmd_if.valid      <= 1'b1;
                    tx_gap = tx_no_idle ? 0 : idle_len();
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each accepted report, shape ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        lsrb_pkg::t_result got;
        lsrb_pkg::t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.link_state         = res_if.link_state;
                got.status_code        = res_if.status_code;
                got.attempt_count      = res_if.attempt_count;
                got.request_rejected   = res_if.request_rejected;
                got.start_tether       = res_if.start_tether;
                got.connect_request    = res_if.connect_request;
                got.disconnect_request = res_if.disconnect_request;
                got.announce_connected = res_if.announce_connected;
                got.heartbeat_due      = res_if.heartbeat_due;
                got.connect_warning    = res_if.connect_warning;
                if (predicted_reports.size() == 0) begin
                    $display("%0t unexpected report: expected none, actual %0h",
                             $time, got);
                    mismatch_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("link_state", 32'(want.link_state), 32'(got.link_state));
                    check_field("status_code", 32'(want.status_code),
                                32'(got.status_code));
                    check_field("attempt_count", 32'(want.attempt_count),
                                32'(got.attempt_count));
                    check_field("request_rejected", 32'(want.request_rejected),
                                32'(got.request_rejected));
                    check_field("start_tether", 32'(want.start_tether),
                                32'(got.start_tether));
                    check_field("connect_request", 32'(want.connect_request),
                                32'(got.connect_request));
                    check_field("disconnect_request", 32'(want.disconnect_request),
                                32'(got.disconnect_request));
                    check_field("announce_connected", 32'(want.announce_connected),
                                32'(got.announce_connected));
                    check_field("heartbeat_due", 32'(want.heartbeat_due),
                                32'(got.heartbeat_due));
                    check_field("connect_warning", 32'(want.connect_warning),
                                32'(got.connect_warning));
                end
            end
            // start a long hold-off when the sequence asks for one
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                rx_hold   = LONG_HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                res_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                rx_gap = rx_no_idle ? 0 : idle_len();
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        cmd_if.valid      = 1'b0;
        cmd_if.command    = lsrb_pkg::CMD_TICK;
        cmd_if.now_ms     = '0;
        cmd_if.link_ready = 1'b0;
        cmd_if.cloud_up   = 1'b0;
        res_if.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = lsrb_pkg::REG_UPDATE_PERIOD;
        i_cfg_data        = '0;
        i_rst_n           = 1'b0;

        // model reset state
        cfg = '{lsrb_pkg::DEF_UPDATE_PERIOD, lsrb_pkg::DEF_HEARTBEAT,
                lsrb_pkg::DEF_CONN_TIMEOUT, lsrb_pkg::DEF_RETRY,
                lsrb_pkg::DEF_BACKOFF, lsrb_pkg::DEF_UPD_MAX,
                lsrb_pkg::DEF_MAX_ATTEMPTS};
        sup        = '0;
        sup.mode   = lsrb_pkg::MODE_CONNECTING;
        sup.status = lsrb_pkg::MODE_CONNECTING;
        link_cond  = 1'b1;
        cloud_cond = 1'b1;
        clock_ms   = '0;
        step_scale = 32'd40;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through every mode with the default settings
        add_cmd(lsrb_pkg::CMD_TICK, 32'd0, 1'b1, 1'b1);          // too early, link up ignored
        add_cmd(lsrb_pkg::CMD_TICK, 32'd999, 1'b1, 1'b1);        // still too early
        add_cmd(lsrb_pkg::CMD_TICK, 32'd1000, 1'b0, 1'b1);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd90001, 1'b1, 1'b0);      // connect warning
        add_cmd(lsrb_pkg::CMD_TICK, 32'd91001, 1'b0, 1'b0);      // warning only once
        add_cmd(lsrb_pkg::CMD_TICK, 32'd92001, 1'b1, 1'b1);      // connected
        add_cmd(lsrb_pkg::CMD_TICK, 32'd93001, 1'b1, 1'b0);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd300500, 1'b1, 1'b1);     // heartbeat
        add_cmd(lsrb_pkg::CMD_RECONNECT, 32'd301000, 1'b1, 1'b1);
        add_cmd(lsrb_pkg::CMD_RECONNECT, 32'd301001, 1'b0, 1'b0); // rejected
        add_cmd(lsrb_pkg::CMD_TICK, 32'd302000, 1'b0, 1'b0);     // retry one
        add_cmd(lsrb_pkg::CMD_TICK, 32'd333000, 1'b1, 1'b0);     // retry two
        add_cmd(lsrb_pkg::CMD_TICK, 32'd364000, 1'b0, 1'b1);     // out of attempts
        add_cmd(lsrb_pkg::CMD_TICK, 32'd365000, 1'b0, 1'b0);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd425000, 1'b0, 1'b0);     // back-off over
        add_cmd(lsrb_pkg::CMD_TICK, 32'd426000, 1'b1, 1'b1);     // status lags behind mode
        add_cmd(lsrb_pkg::CMD_UPD_BEGIN, 32'd427000, 1'b0, 1'b0);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd428000, 1'b0, 1'b0);     // start mark latched
        add_cmd(lsrb_pkg::CMD_TICK, 32'd728000, 1'b0, 1'b0);     // update wait expired
        add_cmd(lsrb_pkg::CMD_UPD_BEGIN, 32'd729000, 1'b1, 1'b1);
        add_cmd(lsrb_pkg::CMD_UPD_DONE, 32'd729500, 1'b1, 1'b1);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd730000, 1'b1, 1'b1);     // finished, stays updating
        add_cmd(lsrb_pkg::CMD_UPD_FAILED, 32'd731000, 1'b1, 1'b1);
        add_cmd(CMD_RSVD_LO, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_cmd(CMD_RSVD_MID, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_cmd(CMD_RSVD_HI, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_cmd(lsrb_pkg::CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0);
        wait_quiet();

        // start mark at time zero counts as not started; period drops to zero
        write_reg(lsrb_pkg::REG_UPDATE_PERIOD, 32'hFFFF_0000);
        @(negedge i_clk);
        add_cmd(lsrb_pkg::CMD_UPD_BEGIN, 32'd0, 1'b0, 1'b0);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd0, 1'b0, 1'b0);
        add_cmd(lsrb_pkg::CMD_TICK, 32'd5, 1'b0, 1'b0);
        add_cmd(lsrb_pkg::CMD_UPD_FAILED, 32'd6, 1'b0, 1'b0);
        wait_quiet();

        // random phases, each under its own settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: apply_config(CFG_SMALL);
                1: apply_config(CFG_SMALL);
                2: apply_config(CFG_DEFAULT);
                3: apply_config(CFG_SMALL);
                4: begin
                    apply_config(CFG_ZERO);
                    write_reg(REG_UNUSED, $urandom);
                    @(negedge i_clk);
                end
                5: apply_config(CFG_SMALL);
                6: apply_config(CFG_FULL);
                default: apply_config(CFG_MIXED);
            endcase
            tx_no_idle = (p == 1 || p == 3);
            rx_no_idle = (p == 3);
            if (p == 1) hold_requests++;
            if (p == 2) clock_ms = clock_ms + 32'd100000;
            if (p == 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) add_random_cmd();
            wait_quiet();
        end

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
